### rtl/asp_pkg.sv
// Shared types, constants and helper functions of the arm pick sequencer.
// No dependencies; every other file of the block imports this package.
package asp_pkg;

    // Fixed-point format of all positions
    localparam int     FRAC_BITS = 16;
    localparam longint FX_ONE    = longint'(1) << FRAC_BITS;

    localparam int POS_W  = 32;
    localparam int TOL_W  = 17;
    localparam int GRIP_W = 8;
    localparam int LIFT_W = 31;
    localparam int SPD_W  = 5;
    localparam int PICK_W = 2;

    // Register reset values
    localparam logic signed [POS_W-1:0] RST_WORK_POS = POS_W'(-((315 * FX_ONE + 50) / 100));
    localparam logic [TOL_W-1:0]        RST_TOL      = TOL_W'((FX_ONE + 5) / 10);
    localparam logic [GRIP_W-1:0]       RST_GRIP     = GRIP_W'(25);
    localparam logic signed [POS_W-1:0] RST_LOWER    = POS_W'(6 * FX_ONE);
    localparam logic signed [POS_W-1:0] RST_DROP     = POS_W'(3 * FX_ONE);
    localparam logic [LIFT_W-1:0]       RST_LIFT     = LIFT_W'(20 * FX_ONE);
    localparam logic signed [POS_W-1:0] RST_FULL     = POS_W'(5 * FX_ONE);

    // Height axis travel speed
    localparam logic [SPD_W-1:0] Z_SPEED = SPD_W'(20);
    localparam logic [SPD_W-1:0] Z_STOP  = SPD_W'(0);

    // Last value of the pick counter before it wraps
    localparam logic [PICK_W-1:0] PICK_LAST = PICK_W'(2);

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_Z_ZERO       = 3'd0,
        REG_WORK_POS_Y   = 3'd1,
        REG_TOLERANCE    = 3'd2,
        REG_GRIP_WAIT    = 3'd3,
        REG_LOWER_HEIGHT = 3'd4,
        REG_DROP_HEIGHT  = 3'd5,
        REG_LIFT_OFFSET  = 3'd6,
        REG_FULL_HEIGHT  = 3'd7
    } asp_reg_t;

    // Sequencer phases
    typedef enum logic [9:0] {
        PH_WAIT_WORK = 10'b00_0000_0001,
        PH_LOWER     = 10'b00_0000_0010,
        PH_GRIP      = 10'b00_0000_0100,
        PH_LIFT_PICK = 10'b00_0000_1000,
        PH_ROTATE    = 10'b00_0001_0000,
        PH_DROP      = 10'b00_0010_0000,
        PH_RELEASE   = 10'b00_0100_0000,
        PH_LIFT_DROP = 10'b00_1000_0000,
        PH_RETURN    = 10'b01_0000_0000,
        PH_FINISH    = 10'b10_0000_0000
    } asp_phase_t;

    typedef struct packed {
        logic signed [POS_W-1:0] z_zero;
        logic signed [POS_W-1:0] work_pos_y;
        logic [TOL_W-1:0]        tolerance;
        logic [GRIP_W-1:0]       grip_wait;
        logic signed [POS_W-1:0] lower_height;
        logic signed [POS_W-1:0] drop_height;
        logic [LIFT_W-1:0]       lift_offset;
        logic signed [POS_W-1:0] full_height;
    } asp_cfg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] dest_y;
        logic signed [POS_W-1:0] meas_y;
        logic signed [POS_W-1:0] meas_z;
        logic                    top_switch;
    } asp_item_t;

    typedef struct packed {
        logic                    done_res;
        logic                    y_cmd_valid;
        logic signed [POS_W-1:0] y_cmd_pos;
        logic                    z_cmd_valid;
        logic signed [POS_W-1:0] z_cmd_pos;
        logic [SPD_W-1:0]        z_cmd_speed;
        logic                    third_pick_flag;
    } asp_result_t;

    // Strict window check: center - tol < meas < center + tol, no overflow
    function automatic logic in_window(input logic signed [POS_W-1:0] meas,
                                       input logic signed [POS_W:0]   center,
                                       input logic [TOL_W-1:0]        tol);
        logic signed [POS_W+2:0] m;
        logic signed [POS_W+2:0] c;
        logic signed [POS_W+2:0] t;
        m = (POS_W+3)'(meas);
        c = (POS_W+3)'(center);
        t = $signed({{(POS_W+3-TOL_W){1'b0}}, tol});
        return (m > c - t) && (m < c + t);
    endfunction

    // Clamp a widened sum to the signed position range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
        logic signed [POS_W+1:0] hi;
        logic signed [POS_W+1:0] lo;
        hi = (POS_W+2)'({1'b0, {(POS_W-1){1'b1}}});
        lo = -hi - (POS_W+2)'(1);
        if (v > hi) begin
            return hi[POS_W-1:0];
        end else if (v < lo) begin
            return lo[POS_W-1:0];
        end
        return v[POS_W-1:0];
    endfunction

endpackage

### rtl/asp_cfg_regs.sv
// Configuration register file of the arm pick sequencer.
// Depends on asp_pkg for register indexes, reset values and the config struct.
module asp_cfg_regs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [2:0]                cfg_index,
    input  logic [asp_pkg::POS_W-1:0] cfg_wdata,
    output asp_pkg::asp_cfg_t         cfg
);
    import asp_pkg::*;

    asp_cfg_t cfg_reg;
    asp_cfg_t cfg_next;

    // Decode the write
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (asp_reg_t'(cfg_index))
                REG_Z_ZERO:       cfg_next.z_zero       = cfg_wdata;
                REG_WORK_POS_Y:   cfg_next.work_pos_y   = cfg_wdata;
                REG_TOLERANCE:    cfg_next.tolerance    = cfg_wdata[TOL_W-1:0];
                REG_GRIP_WAIT:    cfg_next.grip_wait    = cfg_wdata[GRIP_W-1:0];
                REG_LOWER_HEIGHT: cfg_next.lower_height = cfg_wdata;
                REG_DROP_HEIGHT:  cfg_next.drop_height  = cfg_wdata;
                REG_LIFT_OFFSET:  cfg_next.lift_offset  = cfg_wdata[LIFT_W-1:0];
                REG_FULL_HEIGHT:  cfg_next.full_height  = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.z_zero       <= '0;
            cfg_reg.work_pos_y   <= RST_WORK_POS;
            cfg_reg.tolerance    <= RST_TOL;
            cfg_reg.grip_wait    <= RST_GRIP;
            cfg_reg.lower_height <= RST_LOWER;
            cfg_reg.drop_height  <= RST_DROP;
            cfg_reg.lift_offset  <= RST_LIFT;
            cfg_reg.full_height  <= RST_FULL;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/asp_seq_core.sv
// Phase state machine and command generation of the arm pick sequencer.
// Depends on asp_pkg; state advances once per tick when advance is high.
module asp_seq_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  asp_pkg::asp_item_t   item,
    input  asp_pkg::asp_cfg_t    cfg,
    output asp_pkg::asp_result_t res
);
    import asp_pkg::*;

    asp_phase_t              phase_reg, phase_next;
    logic signed [POS_W-1:0] y_hold_reg, y_hold_next;
    logic                    y_hold_valid_reg, y_hold_valid_next;
    logic signed [POS_W-1:0] z_hold_reg, z_hold_next;
    logic                    z_hold_valid_reg, z_hold_valid_next;
    logic [GRIP_W-1:0]       wait_count_reg, wait_count_next;
    logic [PICK_W-1:0]       pick_count_reg, pick_count_next;

    logic                    done;
    logic                    up;
    logic                    flag;
    logic signed [POS_W:0]   drop_center;
    logic signed [POS_W:0]   full_abs;
    logic signed [POS_W+1:0] lift_sum;
    logic signed [POS_W+1:0] hold_sum;

    assign drop_center = (POS_W+1)'(cfg.z_zero) + (POS_W+1)'(cfg.drop_height);
    assign full_abs    = (POS_W+1)'(cfg.z_zero) + (POS_W+1)'(cfg.full_height);
    assign lift_sum    = (POS_W+2)'(cfg.z_zero) - $signed({3'b000, cfg.lift_offset});

    // Phase update
    always_comb begin
        phase_next        = phase_reg;
        y_hold_next       = y_hold_reg;
        y_hold_valid_next = y_hold_valid_reg;
        z_hold_next       = z_hold_reg;
        z_hold_valid_next = z_hold_valid_reg;
        wait_count_next   = wait_count_reg;
        pick_count_next   = pick_count_reg;
        done              = 1'b0;
        up                = 1'b0;
        flag              = 1'b0;
        case (phase_reg)
            PH_WAIT_WORK: begin
                if (in_window(item.meas_y, (POS_W+1)'(cfg.work_pos_y), cfg.tolerance)) begin
                    phase_next = PH_LOWER;
                end
            end
            PH_LOWER: begin
                z_hold_next       = cfg.lower_height;
                z_hold_valid_next = 1'b1;
                phase_next        = PH_GRIP;
            end
            PH_GRIP: begin
                if (wait_count_reg == '0) begin
                    wait_count_next = cfg.grip_wait;
                    phase_next      = PH_LIFT_PICK;
                end else begin
                    wait_count_next = wait_count_reg - GRIP_W'(1);
                end
            end
            PH_LIFT_PICK: begin
                // third pick still below the full-height mark
                flag = (pick_count_reg == PICK_LAST) &&
                       ((POS_W+1)'(item.meas_z) < full_abs);
                z_hold_valid_next = 1'b0;
                up                = 1'b1;
                if (item.top_switch) begin
                    phase_next = PH_ROTATE;
                end
            end
            PH_ROTATE: begin
                y_hold_next       = item.dest_y;
                y_hold_valid_next = 1'b1;
                if (in_window(item.meas_y, (POS_W+1)'(item.dest_y), cfg.tolerance)) begin
                    phase_next = PH_DROP;
                end
            end
            PH_DROP: begin
                z_hold_next       = cfg.drop_height;
                z_hold_valid_next = 1'b1;
                if (in_window(item.meas_z, drop_center, cfg.tolerance)) begin
                    phase_next = PH_RELEASE;
                end
            end
            PH_RELEASE: begin
                phase_next = PH_LIFT_DROP;
            end
            PH_LIFT_DROP: begin
                z_hold_valid_next = 1'b0;
                up                = 1'b1;
                if (item.top_switch) begin
                    phase_next = PH_RETURN;
                end
            end
            PH_RETURN: begin
                y_hold_next       = cfg.work_pos_y;
                y_hold_valid_next = 1'b1;
                if (in_window(item.meas_y, (POS_W+1)'(cfg.work_pos_y), cfg.tolerance)) begin
                    phase_next = PH_FINISH;
                end
            end
            PH_FINISH: begin
                y_hold_valid_next = 1'b0;
                z_hold_valid_next = 1'b0;
                phase_next        = PH_WAIT_WORK;
                pick_count_next   = (pick_count_reg >= PICK_LAST) ? '0
                                                                  : pick_count_reg + PICK_W'(1);
                done              = 1'b1;
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase
    end

    assign hold_sum = (POS_W+2)'(cfg.z_zero) + (POS_W+2)'(z_hold_next);

    // Command outputs from the updated holds
    always_comb begin
        res                 = '0;
        res.done_res        = done;
        res.third_pick_flag = flag;
        if (!done) begin
            if (up) begin
                res.z_cmd_valid = 1'b1;
                res.z_cmd_pos   = sat_pos(lift_sum);
                res.z_cmd_speed = item.top_switch ? Z_STOP : Z_SPEED;
            end
            if (y_hold_valid_next) begin
                res.y_cmd_valid = 1'b1;
                res.y_cmd_pos   = y_hold_next;
            end
            if (z_hold_valid_next) begin
                res.z_cmd_valid = 1'b1;
                res.z_cmd_pos   = sat_pos(hold_sum);
                res.z_cmd_speed = Z_SPEED;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_WAIT_WORK;
            y_hold_reg       <= RST_WORK_POS;
            y_hold_valid_reg <= 1'b1;
            z_hold_reg       <= '0;
            z_hold_valid_reg <= 1'b1;
            wait_count_reg   <= RST_GRIP;
            pick_count_reg   <= '0;
        end else if (advance) begin
            phase_reg        <= phase_next;
            y_hold_reg       <= y_hold_next;
            y_hold_valid_reg <= y_hold_valid_next;
            z_hold_reg       <= z_hold_next;
            z_hold_valid_reg <= z_hold_valid_next;
            wait_count_reg   <= wait_count_next;
            pick_count_reg   <= pick_count_next;
        end
    end

endmodule

### rtl/arm_pick_sequencer_unit.sv
// Arm pick sequencer, top level: request registers, sequencer core, result register.
// Depends on asp_pkg, asp_cfg_regs and asp_seq_core.
// Path: input register, phase update in one pass, result register.
// One request per cycle while the result register is free or m_ready is high.
// Reset (aresetn, synchronous, active low) empties both registers and loads the default
// configuration and the idle phase at the work position; no clearing pass is needed.
module arm_pick_sequencer_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration
    input  logic                      cfg_wr_en,
    input  logic [2:0]                cfg_index,
    input  logic [asp_pkg::POS_W-1:0] cfg_wdata,
    // request channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [asp_pkg::POS_W-1:0] s_dest_y,
    input  logic [asp_pkg::POS_W-1:0] s_meas_y,
    input  logic [asp_pkg::POS_W-1:0] s_meas_z,
    input  logic                      s_top_switch,
    // result channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_done_res,
    output logic                      m_y_cmd_valid,
    output logic [asp_pkg::POS_W-1:0] m_y_cmd_pos,
    output logic                      m_z_cmd_valid,
    output logic [asp_pkg::POS_W-1:0] m_z_cmd_pos,
    output logic [asp_pkg::SPD_W-1:0] m_z_cmd_speed,
    output logic                      m_third_pick_flag
);
    import asp_pkg::*;

    asp_cfg_t    cfg;
    asp_item_t   item_reg;
    logic        in_valid_reg;
    asp_result_t res;
    asp_result_t res_reg;
    logic        m_valid_reg;
    logic        advance;
    logic        s_accept;

    // Pipeline control
    assign advance  = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    asp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    asp_seq_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Request register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.dest_y     <= s_dest_y;
            item_reg.meas_y     <= s_meas_y;
            item_reg.meas_z     <= s_meas_z;
            item_reg.top_switch <= s_top_switch;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_done_res        = res_reg.done_res;
    assign m_y_cmd_valid     = res_reg.y_cmd_valid;
    assign m_y_cmd_pos       = res_reg.y_cmd_pos;
    assign m_z_cmd_valid     = res_reg.z_cmd_valid;
    assign m_z_cmd_pos       = res_reg.z_cmd_pos;
    assign m_z_cmd_speed     = res_reg.z_cmd_speed;
    assign m_third_pick_flag = res_reg.third_pick_flag;

endmodule

### rtl/asp_checker.sv
// Port-level checks of the arm pick sequencer, bound to the top level.
// Depends on asp_pkg for widths and the speed constants.
module asp_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic                      m_done_res,
    input logic                      m_y_cmd_valid,
    input logic [asp_pkg::POS_W-1:0] m_y_cmd_pos,
    input logic                      m_z_cmd_valid,
    input logic [asp_pkg::POS_W-1:0] m_z_cmd_pos,
    input logic [asp_pkg::SPD_W-1:0] m_z_cmd_speed,
    input logic                      m_third_pick_flag
);
    import asp_pkg::*;

    // finishing tick carries no commands
    a_done_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_done_res) |-> (!m_y_cmd_valid && !m_z_cmd_valid))
        else $error("done result carries a command");

    // idle command fields read as zero
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_y_cmd_valid || m_y_cmd_pos == '0) &&
                     (m_z_cmd_valid || (m_z_cmd_pos == '0 && m_z_cmd_speed == Z_STOP))))
        else $error("idle command field not zero");

    // height speed is either stopped or travel speed
    a_speed_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_z_cmd_speed == Z_STOP || m_z_cmd_speed == Z_SPEED))
        else $error("unexpected height speed");

    // third-pick flag only while lifting with a height command
    a_flag_lift: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_third_pick_flag) |-> (m_z_cmd_valid && !m_done_res && !m_y_cmd_valid))
        else $error("third-pick flag outside first lift");

    // a stalled result holds
    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_z_cmd_pos) && $stable(m_y_cmd_pos)))
        else $error("stalled result changed");

endmodule

bind arm_pick_sequencer_unit asp_checker u_asp_checker (.*);

### dv/testbench.sv
// Self-checking testbench for the arm pick sequencer top level (arm_pick_sequencer_unit).
// Depends on rtl/asp_pkg.sv and the RTL files of the block; a built-in phase predictor
// checks every result.
module testbench;
    import asp_pkg::*;

    localparam int IDLE_PCT    = 22;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SMALL_SPAN  = 1 << 23;
    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [2:0]        cfg_index = '0;
    logic [POS_W-1:0]  cfg_wdata = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [POS_W-1:0]  s_dest_y = '0;
    logic [POS_W-1:0]  s_meas_y = '0;
    logic [POS_W-1:0]  s_meas_z = '0;
    logic              s_top_switch = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_done_res;
    logic              m_y_cmd_valid;
    logic [POS_W-1:0]  m_y_cmd_pos;
    logic              m_z_cmd_valid;
    logic [POS_W-1:0]  m_z_cmd_pos;
    logic [SPD_W-1:0]  m_z_cmd_speed;
    logic              m_third_pick_flag;

    arm_pick_sequencer_unit uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_dest_y          (s_dest_y),
        .s_meas_y          (s_meas_y),
        .s_meas_z          (s_meas_z),
        .s_top_switch      (s_top_switch),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_done_res        (m_done_res),
        .m_y_cmd_valid     (m_y_cmd_valid),
        .m_y_cmd_pos       (m_y_cmd_pos),
        .m_z_cmd_valid     (m_z_cmd_valid),
        .m_z_cmd_pos       (m_z_cmd_pos),
        .m_z_cmd_speed     (m_z_cmd_speed),
        .m_third_pick_flag (m_third_pick_flag)
    );

    // Clock, period 4
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Predicted commands still owed by the block, oldest first
    asp_result_t pending_results[$];
    int          mismatches = 0;
    int          hold_left = 0;
    bit          steady = 1'b0;
    int          finished_picks = 0;
    int          cycle_count = 0;

    // Sequencer copy: configuration and state
    asp_cfg_t                cfg;
    asp_phase_t              ph;
    logic signed [POS_W-1:0] y_hold;
    logic                    y_hold_ok;
    logic signed [POS_W-1:0] z_hold;
    logic                    z_hold_ok;
    logic [GRIP_W-1:0]       grip_left;
    logic [PICK_W-1:0]       picks_done;
    logic signed [POS_W-1:0] slot_y = '0;

    function automatic logic signed [POS_W-1:0] clamp32(input longint v);
        if (v > longint'(POS_MAX)) return POS_MAX;
        if (v < longint'(POS_MIN)) return POS_MIN;
        return v[POS_W-1:0];
    endfunction

    // Strict window: center - tol < meas < center + tol, in 64-bit arithmetic
    function automatic logic in_band(input logic signed [POS_W-1:0] meas, input longint center);
        longint m;
        longint t;
        m = longint'($signed(meas));
        t = longint'(cfg.tolerance);
        return (m > center - t) && (m < center + t);
    endfunction

    // One control tick of the sequencer: phase update, then the commands
    function automatic asp_result_t advance_sequencer(input asp_item_t it);
        asp_result_t r;
        logic        lift_up;
        longint      z0;
        r       = '0;
        lift_up = 1'b0;
        z0      = longint'($signed(cfg.z_zero));
        case (ph)
            PH_WAIT_WORK: begin
                if (in_band(it.meas_y, longint'($signed(cfg.work_pos_y)))) ph = PH_LOWER;
            end
            PH_LOWER: begin
                z_hold    = cfg.lower_height;
                z_hold_ok = 1'b1;
                ph        = PH_GRIP;
            end
            PH_GRIP: begin
                if (grip_left == '0) begin
                    grip_left = cfg.grip_wait;
                    ph        = PH_LIFT_PICK;
                end else begin
                    grip_left = grip_left - 1'b1;
                end
            end
            PH_LIFT_PICK: begin
                if (picks_done == PICK_LAST &&
                    longint'($signed(it.meas_z)) < z0 + longint'($signed(cfg.full_height)))
                    r.third_pick_flag = 1'b1;
                z_hold_ok = 1'b0;
                lift_up   = 1'b1;
                if (it.top_switch) ph = PH_ROTATE;
            end
            PH_ROTATE: begin
                y_hold    = it.dest_y;
                y_hold_ok = 1'b1;
                if (in_band(it.meas_y, longint'($signed(it.dest_y)))) ph = PH_DROP;
            end
            PH_DROP: begin
                z_hold    = cfg.drop_height;
                z_hold_ok = 1'b1;
                if (in_band(it.meas_z, z0 + longint'($signed(cfg.drop_height)))) ph = PH_RELEASE;
            end
            PH_RELEASE: begin
                ph = PH_LIFT_DROP;
            end
            PH_LIFT_DROP: begin
                z_hold_ok = 1'b0;
                lift_up   = 1'b1;
                if (it.top_switch) ph = PH_RETURN;
            end
            PH_RETURN: begin
                y_hold    = cfg.work_pos_y;
                y_hold_ok = 1'b1;
                if (in_band(it.meas_y, longint'($signed(cfg.work_pos_y)))) ph = PH_FINISH;
            end
            PH_FINISH: begin
                y_hold_ok  = 1'b0;
                z_hold_ok  = 1'b0;
                ph         = PH_WAIT_WORK;
                picks_done = (picks_done >= PICK_LAST) ? '0 : picks_done + 1'b1;
                r.done_res = 1'b1;
                finished_picks++;
            end
            default: ;
        endcase

        // No commands on the finishing tick; a held height overrides the lift
        if (!r.done_res) begin
            if (lift_up) begin
                r.z_cmd_valid = 1'b1;
                r.z_cmd_pos   = clamp32(z0 - longint'(cfg.lift_offset));
                r.z_cmd_speed = it.top_switch ? Z_STOP : Z_SPEED;
            end
            if (y_hold_ok) begin
                r.y_cmd_valid = 1'b1;
                r.y_cmd_pos   = y_hold;
            end
            if (z_hold_ok) begin
                r.z_cmd_valid = 1'b1;
                r.z_cmd_pos   = clamp32(z0 + longint'($signed(z_hold)));
                r.z_cmd_speed = Z_SPEED;
            end
        end
        return r;
    endfunction

    // Value around a window center: mostly inside, sometimes on the edge, sometimes anywhere
    function automatic logic signed [POS_W-1:0] near_value(input longint center,
                                                           input longint spread);
        longint off;
        int     pick;
        pick = $urandom_range(0, 9);
        off  = 0;
        if (pick <= 5) begin
            if (spread > 0) off = longint'($urandom_range(0, 2 * spread - 2)) - (spread - 1);
        end else if (pick == 6) begin
            off = spread;
        end else if (pick == 7) begin
            off = -spread;
        end else if (pick == 8) begin
            off = (spread > 0) ? spread - 1 : 1;
        end else begin
            return $urandom;
        end
        return clamp32(center + off);
    endfunction

    // Position: full range one time in n, else a small value around zero
    function automatic logic signed [POS_W-1:0] pick_pos(input int n);
        if ($urandom_range(0, n - 1) == 0) return $urandom;
        return int'($urandom_range(0, SMALL_SPAN)) - SMALL_SPAN / 2;
    endfunction

    // Next tick: follows the current phase unless it is noise
    function automatic asp_item_t make_tick(input bit noise);
        asp_item_t it;
        longint    z0;
        longint    tol;
        z0            = longint'($signed(cfg.z_zero));
        tol           = longint'(cfg.tolerance);
        it.dest_y     = $urandom;
        it.meas_y     = $urandom;
        it.meas_z     = $urandom;
        it.top_switch = $urandom_range(0, 1);
        if (noise) return it;
        case (ph)
            PH_WAIT_WORK, PH_RETURN: begin
                it.meas_y = near_value(longint'($signed(cfg.work_pos_y)), tol);
            end
            PH_LIFT_PICK: begin
                it.meas_z     = near_value(z0 + longint'($signed(cfg.full_height)), 2);
                it.top_switch = ($urandom_range(0, 2) == 0);
            end
            PH_LIFT_DROP: begin
                it.top_switch = ($urandom_range(0, 2) == 0);
            end
            PH_ROTATE: begin
                it.dest_y = slot_y;
                it.meas_y = near_value(longint'(slot_y), tol);
            end
            PH_DROP: begin
                it.meas_z = near_value(z0 + longint'($signed(cfg.drop_height)), tol);
            end
            PH_FINISH: begin
                slot_y = pick_pos(3);
            end
            default: ;
        endcase
        return it;
    endfunction

    function automatic asp_cfg_t random_setting();
        asp_cfg_t c;
        c.z_zero       = pick_pos(5);
        c.work_pos_y   = pick_pos(3);
        c.tolerance    = ($urandom_range(0, 9) == 0) ? '0 : TOL_W'($urandom_range(1, 65536));
        c.grip_wait    = ($urandom_range(0, 9) == 0) ? GRIP_W'($urandom) :
                                                       GRIP_W'($urandom_range(0, 5));
        c.lower_height = pick_pos(4);
        c.drop_height  = pick_pos(6);
        c.lift_offset  = ($urandom_range(0, 4) == 0) ? LIFT_W'($urandom) :
                                                       LIFT_W'($urandom_range(0, SMALL_SPAN));
        c.full_height  = pick_pos(4);
        return c;
    endfunction

    // Send one request; idles first at random, then holds valid until it is taken
    task automatic send_request(input asp_item_t it);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_dest_y     <= it.dest_y;
        s_meas_y     <= it.meas_y;
        s_meas_z     <= it.meas_z;
        s_top_switch <= it.top_switch;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(advance_sequencer(it));
    endtask

    // Ticks until the given number of picks has finished or the cap is reached
    task automatic run_picks(input int picks, input int cap, input int noise_pct);
        int goal;
        int sent;
        goal = finished_picks + picks;
        sent = 0;
        while (finished_picks < goal && sent < cap) begin
            send_request(make_tick($urandom_range(0, 99) < noise_pct));
            sent++;
        end
    endtask

    // Stop sending, wait for every owed result, then let the pipeline settle
    task automatic quiesce(input int pause);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (pause) @(posedge aclk);
    endtask

    // Write all eight registers; narrow ones sometimes carry junk above their width
    task automatic set_config(input asp_cfg_t c);
        asp_reg_t         r;
        logic [POS_W-1:0] d;
        bit               junk;
        quiesce(4);
        r = r.first();
        repeat (r.num()) begin
            junk = ($urandom_range(0, 3) == 0);
            case (r)
                REG_Z_ZERO:       d = c.z_zero;
                REG_WORK_POS_Y:   d = c.work_pos_y;
                REG_TOLERANCE:    d = {junk ? 15'($urandom) : 15'd0, c.tolerance};
                REG_GRIP_WAIT:    d = {junk ? 24'($urandom) : 24'd0, c.grip_wait};
                REG_LOWER_HEIGHT: d = c.lower_height;
                REG_DROP_HEIGHT:  d = c.drop_height;
                REG_LIFT_OFFSET:  d = {junk ? 1'($urandom) : 1'b0, c.lift_offset};
                default:          d = c.full_height;
            endcase
            cfg_wr_en <= 1'b1;
            cfg_index <= r;
            cfg_wdata <= d;
            @(posedge aclk);
            r = r.next();
        end
        cfg_wr_en <= 1'b0;
        cfg = c;
    endtask

    task automatic check_field(input string name, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result checker and receiver ready
    always @(posedge aclk) begin : result_monitor
        asp_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual done=%b y=%b/%h z=%b/%h/%0d flag=%b",
                         $time, m_done_res, m_y_cmd_valid, m_y_cmd_pos, m_z_cmd_valid,
                         m_z_cmd_pos, m_z_cmd_speed, m_third_pick_flag);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("done_res", want.done_res, m_done_res);
                check_field("y_cmd_valid", want.y_cmd_valid, m_y_cmd_valid);
                check_field("y_cmd_pos", want.y_cmd_pos, m_y_cmd_pos);
                check_field("z_cmd_valid", want.z_cmd_valid, m_z_cmd_valid);
                check_field("z_cmd_pos", want.z_cmd_pos, m_z_cmd_pos);
                check_field("z_cmd_speed", want.z_cmd_speed, m_z_cmd_speed);
                check_field("third_pick_flag", want.third_pick_flag, m_third_pick_flag);
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Reset defaults, then window edges and field extremes while waiting at work position
    task automatic test_reset_state();
        longint w;
        longint t;
        w = longint'($signed(cfg.work_pos_y));
        t = longint'(cfg.tolerance);
        send_request('{dest_y: POS_MAX, meas_y: clamp32(w + t), meas_z: POS_MIN, top_switch: 1'b1});
        send_request('{dest_y: POS_MIN, meas_y: clamp32(w - t), meas_z: POS_MAX, top_switch: 1'b0});
        send_request('{dest_y: '0, meas_y: POS_MAX, meas_z: '1, top_switch: 1'b1});
        send_request('{dest_y: '1, meas_y: POS_MIN, meas_z: '0, top_switch: 1'b0});
        send_request('{dest_y: '0, meas_y: clamp32(w - t + 1), meas_z: '0, top_switch: 1'b0});
        send_request('{dest_y: '1, meas_y: '1, meas_z: '1, top_switch: 1'b1});
    endtask

    // Rest of the first pick on reset configuration (grip count from reset)
    task automatic test_first_pick();
        run_picks(1, 300, 0);
    endtask

    // Saturating heights, widest, narrowest and empty windows, longest grip
    task automatic test_config_extremes();
        asp_cfg_t c;
        c = '{z_zero: POS_MAX, work_pos_y: POS_MAX, tolerance: TOL_W'(65536), grip_wait: '0,
              lower_height: POS_MAX, drop_height: POS_MIN, lift_offset: '1,
              full_height: POS_MIN};
        set_config(c);
        run_picks(3, 400, 0);
        c = '{z_zero: POS_MIN, work_pos_y: POS_MIN, tolerance: TOL_W'(1), grip_wait: '1,
              lower_height: POS_MIN, drop_height: POS_MAX, lift_offset: '1,
              full_height: POS_MAX};
        set_config(c);
        run_picks(1, 350, 0);
        c = '0;
        set_config(c);
        run_picks(12, 12, 0);
    endtask

    // Back-to-back stream with no idling on either side
    task automatic test_steady_stream();
        asp_cfg_t c;
        c = random_setting();
        c.tolerance = TOL_W'(65536);
        c.grip_wait = GRIP_W'(1);
        set_config(c);
        steady = 1'b1;
        run_picks(4, 200, 10);
        steady = 1'b0;
    endtask

    // Many random settings, each with a run of mostly well-formed ticks
    task automatic test_random_settings();
        int done_items;
        int n;
        done_items = 0;
        while (done_items < 200) begin
            set_config(random_setting());
            n = $urandom_range(40, 120);
            run_picks(n, n, 15);
            done_items += n;
        end
    endtask

    // Receiver holds off while the sender keeps offering requests
    task automatic test_receiver_stall();
        quiesce(4);
        @(negedge aclk);
        hold_left = 300;
        @(posedge aclk);
        steady = 1'b1;
        run_picks(40, 40, 10);
        steady = 1'b0;
    endtask

    initial begin
        cfg = '{z_zero: '0, work_pos_y: RST_WORK_POS, tolerance: RST_TOL, grip_wait: RST_GRIP,
                lower_height: RST_LOWER, drop_height: RST_DROP, lift_offset: RST_LIFT,
                full_height: RST_FULL};
        ph         = PH_WAIT_WORK;
        y_hold     = RST_WORK_POS;
        y_hold_ok  = 1'b1;
        z_hold     = '0;
        z_hold_ok  = 1'b1;
        grip_left  = RST_GRIP;
        picks_done = '0;
        slot_y     = pick_pos(3);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_first_pick();
        test_config_extremes();
        test_steady_stream();
        test_random_settings();
        test_receiver_stall();
        quiesce(8);

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
